### sv/no_adjacent_repeat_scheduler_assert.svh
// Assertion macros for the no-adjacent-repeat scheduler.
// The IMP form checks an implication in the same cycle and the NXT form
// checks it in the following cycle. Both are empty when SYNTH is defined.
`ifndef NO_ADJACENT_REPEAT_SCHEDULER_ASSERT_SVH
`define NO_ADJACENT_REPEAT_SCHEDULER_ASSERT_SVH

`ifndef SYNTH

`define NARS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define NARS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NARS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define NARS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/nars_pkg.sv
package nars_pkg;

  // Store limits and letter alphabet
  localparam int MAX_LEN  = 4096;
  localparam int ALPHABET = 26;
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int LTR_W    = 5;

  // Padded comparison tree over the letter counters
  localparam int TREE_LV  = $clog2(ALPHABET);
  localparam int TREE_N   = 1 << TREE_LV;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_PULL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_IMPOSSIBLE = 2'd1,
    ST_EMPTY      = 2'd2
  } status_e;

  typedef logic [ALPHABET-1:0][CNT_W-1:0] counts_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [LTR_W-1:0] idx;
  } best_t;

  // Largest eligible count, ties to the higher letter code.
  // A zero count means no letter qualifies.
  function automatic best_t pick_best(input counts_t cnt, input logic [ALPHABET-1:0] elig);
    best_t node [TREE_N];
    for (int i = 0; i < TREE_N; i++) begin
      node[i].cnt = '0;
      node[i].idx = LTR_W'(i);
    end
    for (int i = 0; i < ALPHABET; i++) begin
      if (elig[i]) begin
        node[i].cnt = cnt[i];
      end
    end
    // Reduce pairwise; the right node holds the higher codes and wins a tie
    for (int lvl = 0; lvl < TREE_LV; lvl++) begin
      for (int j = 0; j < (TREE_N >> (lvl + 1)); j++) begin
        node[j] = (node[2*j+1].cnt >= node[2*j].cnt) ? node[2*j+1] : node[2*j];
      end
    end
    return node[0];
  endfunction

endpackage

### sv/no_adjacent_repeat_scheduler.sv
// No-adjacent-repeat letter scheduler.
// Input stream: tuser carries the command (0 = add, 1 = pull), tdata[4:0]
// carries the letter to add (0..25, ignored on pull). Adds produce no result;
// each pull produces one result on the output stream: tdata[4:0] is the
// letter, tuser the status (0 = letter, 1 = no arrangement, 2 = empty), and
// tlast marks the end of a sequence.
// Every request first lands in an input register; from there the letter
// counters are updated and a pull result is written to the output register,
// where it is presented until the receiver takes it.
// One request per cycle is sustained unless a pull waits on a stalled
// receiver; a single 26-way compare tree lies between the counters and the output register.
// Reset clears all counters, the running total and the sequence state at
// once; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register; adds
// keep flowing, a pull waits in the input register, and tready drops only
// while that pull cannot be written.
module no_adjacent_repeat_scheduler
  import nars_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [4:0] letter_in, [7:5] zero
  input  logic       s_axis_tuser_i,   // [0] cmd
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [4:0] letter_out, [7:5] zero
  output logic [1:0] m_axis_tuser_o,   // [1:0] status
  output logic       m_axis_tlast_o    // is_last
);

  `include "no_adjacent_repeat_scheduler_assert.svh"

  // Input register
  logic             in_valid_q;
  cmd_e             in_cmd_q;
  logic [LTR_W-1:0] in_ltr_q;

  // Scheduler state
  counts_t          cnt_q, cnt_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [LTR_W-1:0] prev_q, prev_d;
  logic             have_prev_q, have_prev_d;
  logic             emitting_q, emitting_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [LTR_W-1:0] out_ltr_q, out_ltr_d;
  status_e          out_status_q, out_status_d;
  logic             out_last_q, out_last_d;

  logic                out_free;
  logic                fire;
  logic                fire_pull;
  logic [ALPHABET-1:0] elig;
  best_t               best;
  logic [CNT_W:0]      half_total;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && ((in_cmd_q == CMD_ADD) || out_free);
  assign fire_pull       = fire && (in_cmd_q == CMD_PULL);
  assign s_axis_tready_o = !in_valid_q || fire;

  // Mask the letter emitted last
  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      elig[i] = !(have_prev_q && (prev_q == LTR_W'(i)));
    end
  end

  assign best       = pick_best(cnt_q, elig);
  assign half_total = ({1'b0, total_q} + (CNT_W+1)'(1)) >> 1;

  // Next state of counters and result
  always_comb begin
    cnt_d        = cnt_q;
    total_d      = total_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    emitting_d   = emitting_q;
    out_ltr_d    = out_ltr_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;

    if (fire && (in_cmd_q == CMD_ADD)) begin
      // Drop adds while emitting, out of range, or with the store full
      if (!emitting_q && (in_ltr_q < LTR_W'(ALPHABET)) && (total_q < CNT_W'(MAX_LEN))) begin
        for (int i = 0; i < ALPHABET; i++) begin
          if (in_ltr_q == LTR_W'(i)) begin
            cnt_d[i] = cnt_q[i] + CNT_W'(1);
          end
        end
        total_d = total_q + CNT_W'(1);
      end
    end else if (fire_pull) begin
      out_valid_d = 1'b1;
      out_ltr_d   = '0;
      out_last_d  = 1'b1;
      if (total_q == '0) begin
        out_status_d = ST_EMPTY;
      end else if ((!emitting_q && ({1'b0, best.cnt} > half_total)) || (best.cnt == '0)) begin
        // No arrangement: clear the store
        out_status_d = ST_IMPOSSIBLE;
        cnt_d        = '0;
        total_d      = '0;
        prev_d       = '0;
        have_prev_d  = 1'b0;
        emitting_d   = 1'b0;
      end else begin
        out_status_d = ST_OK;
        out_ltr_d    = best.idx;
        for (int i = 0; i < ALPHABET; i++) begin
          if (best.idx == LTR_W'(i)) begin
            cnt_d[i] = cnt_q[i] - CNT_W'(1);
          end
        end
        total_d     = total_q - CNT_W'(1);
        prev_d      = best.idx;
        have_prev_d = 1'b1;
        emitting_d  = 1'b1;
        out_last_d  = (total_q == CNT_W'(1));
        // Last letter: return to the reset state
        if (total_q == CNT_W'(1)) begin
          cnt_d       = '0;
          prev_d      = '0;
          have_prev_d = 1'b0;
          emitting_d  = 1'b0;
        end
      end
    end
  end

  // Capture a request into the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q <= cmd_e'(s_axis_tuser_i);
      in_ltr_q <= s_axis_tdata_i[LTR_W-1:0];
    end
  end

  // Scheduler state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      total_q     <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      emitting_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      emitting_q  <= emitting_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_ltr_q    <= out_ltr_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(8 - LTR_W)'(0), out_ltr_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  `NARS_ASSERT_IMP(a_empty_not_emitting, clk_i, rst_ni, (total_q == '0), !emitting_q,
    "emitting with an empty store")
  `NARS_ASSERT_NXT(a_last_clears, clk_i, rst_ni,
    (fire_pull && out_last_d && (out_status_d == ST_OK)), (total_q == '0) && !have_prev_q,
    "store not cleared after the last letter")
  `NARS_ASSERT_IMP(a_error_is_last, clk_i, rst_ni,
    (out_valid_q && (out_status_q != ST_OK)), out_last_q && (out_ltr_q == '0),
    "error result without last or with a letter")
  `NARS_ASSERT_NXT(a_no_repeat, clk_i, rst_ni,
    (fire_pull && have_prev_q && (out_status_d == ST_OK)), (out_ltr_q != $past(prev_q)),
    "letter repeated")

endmodule

### sim/tb_no_adjacent_repeat_scheduler.sv
`timescale 1ns / 1ps

module tb_no_adjacent_repeat_scheduler;
  import nars_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_REQS   = 1250;
  localparam int SETTLE_CYCLES = 8;

  // One request toward the scheduler, with the idle cycles that precede it
  typedef struct {
    cmd_e       op;
    logic [4:0] ltr;
    int         gap;
    bit         drain_first;
  } request_t;

  // One scheduled letter or refusal as the scheduler should report it
  typedef struct {
    logic [4:0] ltr;
    status_e    st;
    logic       fin;
  } pick_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tuser  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // Stimulus and scoreboard
  request_t    letter_requests[$];
  pick_t       due_picks[$];
  request_t    cur_req;
  pick_t       want;
  int          reqs_sent     = 0;
  int          reqs_taken    = 0;
  int          results_seen  = 0;
  int          mismatches    = 0;
  int          cycle_count   = 0;
  int          gap_left      = 0;
  bit          gap_armed     = 1'b0;
  bit          tx_quiet      = 1'b0;
  int          stall_left    = 0;
  int          rx_mark       = 0;
  bit          rx_quiet      = 1'b0;
  int          n_letters     = 0;
  int          n_refused     = 0;
  int          n_empty       = 0;

  // Shadow of the letter store
  int unsigned tally[ALPHABET];
  int unsigned held_total  = 0;
  logic [4:0]  last_pick   = '0;
  bit          last_valid  = 1'b0;
  bit          in_sequence = 1'b0;

  no_adjacent_repeat_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Drop every letter and the sequence state
  task automatic empty_store();
    foreach (tally[i]) tally[i] = 0;
    held_total  = 0;
    last_pick   = '0;
    last_valid  = 1'b0;
    in_sequence = 1'b0;
  endtask

  // Apply one accepted request to the shadow store and, for a pull, queue its pick
  task automatic track_request(input cmd_e op, input logic [4:0] ltr);
    int unsigned largest;
    int unsigned best_cnt;
    int          best;
    pick_t       res;
    largest  = 0;
    best_cnt = 0;
    best     = 0;
    res.ltr  = '0;
    res.st   = ST_OK;
    res.fin  = 1'b1;
    if (op == CMD_ADD) begin
      // Adds are dropped while emitting, out of range, or with a full store
      if (!in_sequence && ltr < ALPHABET && held_total < MAX_LEN) begin
        tally[ltr]++;
        held_total++;
      end
    end else begin
      if (held_total == 0) begin
        res.st = ST_EMPTY;
      end else begin
        // The first pull checks that an arrangement exists at all
        if (!in_sequence) begin
          foreach (tally[i]) if (tally[i] > largest) largest = tally[i];
          if (largest > (held_total + 1) / 2) begin
            empty_store();
            res.st = ST_IMPOSSIBLE;
          end else begin
            in_sequence = 1'b1;
            last_valid  = 1'b0;
          end
        end
        if (res.st == ST_OK) begin
          // Highest count other than the previous letter, ties to the higher code
          for (int i = 0; i < ALPHABET; i++) begin
            if (tally[i] != 0 && !(last_valid && i == last_pick) && tally[i] >= best_cnt) begin
              best_cnt = tally[i];
              best     = i;
            end
          end
          if (best_cnt == 0) begin
            empty_store();
            res.st = ST_IMPOSSIBLE;
          end else begin
            tally[best]--;
            held_total--;
            last_pick  = 5'(best);
            last_valid = 1'b1;
            res.ltr    = 5'(best);
            res.fin    = (held_total == 0);
            if (held_total == 0) empty_store();
          end
        end
      end
      case (res.st)
        ST_OK:         n_letters++;
        ST_IMPOSSIBLE: n_refused++;
        default:       n_empty++;
      endcase
      due_picks.push_back(res);
    end
  endtask

  // Queue one request with a random lead-in gap, or none while the sender is quiet
  task automatic queue_req(input cmd_e op, input logic [4:0] ltr, input bit drain);
    request_t r;
    r.op          = op;
    r.ltr         = ltr;
    r.gap         = tx_quiet ? 0 : $urandom_range(0, 4);
    r.drain_first = drain;
    letter_requests.push_back(r);
  endtask

  // Sender: present requests at the falling edge, hold until taken
  always @(negedge clk_i) begin
    if (rst_ni && reqs_sent == reqs_taken) begin
      if (!gap_armed && letter_requests.size() > 0) begin
        gap_left  = letter_requests[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_armed && gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (gap_armed && !(letter_requests[0].drain_first && due_picks.size() > 0)) begin
        cur_req   = letter_requests.pop_front();
        s_tdata  <= {3'b000, cur_req.ltr};
        s_tuser  <= cur_req.op;
        s_tvalid <= 1'b1;
        reqs_sent++;
        gap_armed = 1'b0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall a random number of cycles before each result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_seen != rx_mark) begin
        rx_mark    = results_seen;
        stall_left = rx_quiet ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 99) == 0) rx_quiet = !rx_quiet;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: check results first, then account for the new request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (due_picks.size() == 0) begin
          $error("Result with no pull pending: letter %0d status %0d last %0d",
                 m_tdata[4:0], m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = due_picks.pop_front();
          if (m_tdata[4:0] !== want.ltr) begin
            $error("letter_out: expected %0d, got %0d", want.ltr, m_tdata[4:0]);
            mismatches++;
          end
          if (m_tdata[7:5] !== 3'b000) begin
            $error("tdata pad: expected 0, got %0d", m_tdata[7:5]);
            mismatches++;
          end
          if (m_tuser !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, m_tuser);
            mismatches++;
          end
          if (m_tlast !== want.fin) begin
            $error("is_last: expected %0d, got %0d", want.fin, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        reqs_taken++;
        track_request(cmd_e'(s_tuser), s_tdata[4:0]);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d picks outstanding", cycle_count, due_picks.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int seq_len;
    int base;
    int span;
    int pulls;
    int pick_r;
    empty_store();

    // Directed: empty pulls, ignored letters, extremes, ties, refusal
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_ADD, 5'(ALPHABET), 1'b0);
    queue_req(CMD_ADD, 5'h1F, 1'b0);
    queue_req(CMD_PULL, 5'h1F, 1'b0);
    queue_req(CMD_ADD, 5'd0, 1'b0);
    queue_req(CMD_ADD, 5'(ALPHABET - 1), 1'b0);
    queue_req(CMD_ADD, 5'(ALPHABET - 1), 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_ADD, 5'd3, 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_ADD, 5'd4, 1'b1);
    queue_req(CMD_ADD, 5'd4, 1'b0);
    queue_req(CMD_ADD, 5'd4, 1'b0);
    queue_req(CMD_ADD, 5'd9, 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_ADD, 5'd1, 1'b0);
    queue_req(CMD_ADD, 5'd2, 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);
    queue_req(CMD_PULL, 5'd0, 1'b0);

    // Random: mostly load-then-drain sequences over a few letters, some noise
    while (letter_requests.size() < RANDOM_REQS) begin
      if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          queue_req(cmd_e'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), 1'b0);
      end else begin
        seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        base    = $urandom_range(0, ALPHABET - 1);
        span    = $urandom_range(1, 6);
        for (int k = 0; k < seq_len; k++) begin
          if ($urandom_range(0, 15) == 0)
            queue_req(CMD_ADD, 5'($urandom_range(ALPHABET, 31)), 1'b0);
          else
            queue_req(CMD_ADD, 5'((base + $urandom_range(0, span - 1)) % ALPHABET),
                      k == 0 && $urandom_range(0, 29) == 0);
        end
        pick_r = $urandom_range(0, 9);
        pulls  = (pick_r == 0) ? seq_len - 1 : (pick_r <= 3) ? seq_len + 1 : seq_len;
        for (int k = 0; k < pulls; k++) begin
          // Adds between the pulls of a drain are dropped while a sequence is being emitted
          if ($urandom_range(0, 11) == 0)
            queue_req(CMD_ADD, 5'($urandom_range(0, ALPHABET - 1)), 1'b0);
          queue_req(CMD_PULL, 5'($urandom_range(0, 31)), 1'b0);
        end
      end
    end

    // Reset, then let the driver and monitor run
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (letter_requests.size() > 0 || reqs_sent != reqs_taken) @(posedge clk_i);
    while (due_picks.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests in %0d cycles under random gaps and receiver stalls",
             reqs_taken, cycle_count);
    $display("Checked %0d results: %0d letters, %0d refused arrangements, %0d empty pulls",
             results_seen, n_letters, n_refused, n_empty);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### no_adjacent_repeat_scheduler.f
+incdir+sv
sv/nars_pkg.sv
sv/no_adjacent_repeat_scheduler.sv
sim/tb_no_adjacent_repeat_scheduler.sv
